// ===== rtl/lpac_pkg.sv =====
// ----------------------------------------------------------------------------
// lpac_pkg
// Shared types, constants and the CORDIC arctangent table for the lidar point
// angle correction block.
// ----------------------------------------------------------------------------
package lpac_pkg;

   // number of CORDIC vectoring iterations (8..24)
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int STEP_W       = 5;

   localparam int DIST_W  = 16;
   localparam int ANGLE_W = 16;
   localparam int INTEN_W = 8;
   localparam int STAMP_W = 32;
   localparam int CFG_W   = 16;
   localparam int PROD_W  = 32;
   localparam int XY_W    = 28;   // x/y in 1/256 mm plus CORDIC gain
   localparam int Z_W     = 24;   // angle in 1/256 hundredth of a degree
   localparam int SHIFT_W = 15;
   localparam int ANG_W   = 19;   // signed working width of the corrected angle
   localparam int DATA_W  = DIST_W + ANGLE_W + INTEN_W + STAMP_W;
   localparam int INDEX_W = 4;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   // register indexes of the configuration port
   localparam logic [INDEX_W-1:0] REG_RIGHT_HAND = 4'd0;
   localparam logic [INDEX_W-1:0] REG_OFFSET_X   = 4'd1;
   localparam logic [INDEX_W-1:0] REG_OFFSET_Y   = 4'd2;
   localparam logic [INDEX_W-1:0] REG_SLOPE      = 4'd3;

   localparam logic signed [CFG_W-1:0] OFFSET_X_RESET = 16'sd1510;
   localparam logic signed [CFG_W-1:0] OFFSET_Y_RESET = -16'sd4858;
   localparam logic [CFG_W-1:0]        SLOPE_RESET    = 16'd7814;

   localparam logic signed [SHIFT_W-1:0] QUARTER_TURN = 15'sd9000;
   localparam logic signed [ANG_W-1:0]   FULL_TURN    = 19'sd36000;
   localparam logic signed [Z_W-1:0]     ROUND_HALF   = 24'sd128;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_ITER,
      ST_ROUND,
      ST_FINISH
   } lpac_state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic prep;
      logic iter;
      logic round;
      logic finish;
   } lpac_cmd_type;

   typedef struct packed {
      logic in_zero;
      logic last_iter;
      logic out_free;
   } lpac_stat_type;

   // atan(2^-i) in hundredths of a degree times 256
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] r;
      case (idx)
         5'd0:    r = 24'sd1152000;
         5'd1:    r = 24'sd680065;
         5'd2:    r = 24'sd359328;
         5'd3:    r = 24'sd182400;
         5'd4:    r = 24'sd91554;
         5'd5:    r = 24'sd45822;
         5'd6:    r = 24'sd22916;
         5'd7:    r = 24'sd11459;
         5'd8:    r = 24'sd5730;
         5'd9:    r = 24'sd2865;
         5'd10:   r = 24'sd1432;
         5'd11:   r = 24'sd716;
         5'd12:   r = 24'sd358;
         5'd13:   r = 24'sd179;
         5'd14:   r = 24'sd90;
         5'd15:   r = 24'sd45;
         5'd16:   r = 24'sd22;
         5'd17:   r = 24'sd11;
         5'd18:   r = 24'sd6;
         5'd19:   r = 24'sd3;
         5'd20:   r = 24'sd1;
         5'd21:   r = 24'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/lpac_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpac_ctrl
// Sequencer for one point: capture, multiply, form x/y, CORDIC iterations,
// rounding and the final angle correction.
// ----------------------------------------------------------------------------
module lpac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lpac_pkg::lpac_stat_type stat,
   output lpac_pkg::lpac_cmd_type  cmd
);

   lpac_pkg::lpac_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpac_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpac_pkg::ST_IDLE: begin
            // zero-distance items are dropped right here
            if (req_tvalid && !stat.in_zero) state_in = lpac_pkg::ST_MUL;
         end
         lpac_pkg::ST_MUL:   state_in = lpac_pkg::ST_PREP;
         lpac_pkg::ST_PREP:  state_in = lpac_pkg::ST_ITER;
         lpac_pkg::ST_ITER: begin
            if (stat.last_iter) state_in = lpac_pkg::ST_ROUND;
         end
         lpac_pkg::ST_ROUND: state_in = lpac_pkg::ST_FINISH;
         lpac_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = lpac_pkg::ST_IDLE;
         end
         default: state_in = lpac_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         lpac_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         lpac_pkg::ST_MUL:    cmd.mul    = 1'b1;
         lpac_pkg::ST_PREP:   cmd.prep   = 1'b1;
         lpac_pkg::ST_ITER:   cmd.iter   = 1'b1;
         lpac_pkg::ST_ROUND:  cmd.round  = 1'b1;
         lpac_pkg::ST_FINISH: cmd.finish = stat.out_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/lpac_datapath.sv =====
// ----------------------------------------------------------------------------
// lpac_datapath
// Configuration registers, point capture, slope multiplier, shared CORDIC
// vectoring unit, angle correction and the output register.
// ----------------------------------------------------------------------------
module lpac_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [lpac_pkg::DATA_W-1:0]          req_tdata,
   input  logic                                 csr_valid,
   input  logic [lpac_pkg::INDEX_W-1:0]         csr_index,
   input  logic [lpac_pkg::CFG_W-1:0]           csr_data,
   output logic [lpac_pkg::DATA_W-1:0]          rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  lpac_pkg::lpac_cmd_type                cmd,
   output lpac_pkg::lpac_stat_type               stat
);

   localparam int XY_W  = lpac_pkg::XY_W;
   localparam int Z_W   = lpac_pkg::Z_W;
   localparam int ANG_W = lpac_pkg::ANG_W;

   // configuration
   logic                               right_hand_ff;
   logic signed [lpac_pkg::CFG_W-1:0]  offset_x_ff, offset_y_ff;
   logic [lpac_pkg::CFG_W-1:0]         slope_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         right_hand_ff <= 1'b0;
         offset_x_ff   <= lpac_pkg::OFFSET_X_RESET;
         offset_y_ff   <= lpac_pkg::OFFSET_Y_RESET;
         slope_ff      <= lpac_pkg::SLOPE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            lpac_pkg::REG_RIGHT_HAND: right_hand_ff <= csr_data[0];
            lpac_pkg::REG_OFFSET_X:   offset_x_ff   <= csr_data;
            lpac_pkg::REG_OFFSET_Y:   offset_y_ff   <= csr_data;
            lpac_pkg::REG_SLOPE:      slope_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // point capture
   logic [lpac_pkg::DIST_W-1:0]  dist_ff;
   logic [lpac_pkg::ANGLE_W-1:0] raw_ff;
   logic [lpac_pkg::INTEN_W-1:0] inten_ff;
   logic [lpac_pkg::STAMP_W-1:0] stamp_ff;

   assign stat.in_zero = (req_tdata[15:0] == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dist_ff  <= req_tdata[15:0];
         raw_ff   <= req_tdata[31:16];
         inten_ff <= req_tdata[39:32];
         stamp_ff <= req_tdata[71:40];
      end
   end

   // distance times slope
   logic [lpac_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= dist_ff * slope_ff;
   end

   // x/y forming with sign fold, then CORDIC iterations
   logic signed [XY_W-1:0]  x_raw, y_raw;
   logic signed [XY_W-1:0]  x_ff, y_ff, x_in, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic [lpac_pkg::STEP_W-1:0] step_ff, step_in;
   logic                    xzero_ff, ypos_ff, yneg_ff;
   logic signed [XY_W-1:0]  dx, dy;

   assign x_raw = $signed({4'b0000, dist_ff, 8'h00})
                + XY_W'(offset_x_ff);
   assign y_raw = $signed({4'b0000, prod_ff[31:8]})
                + XY_W'(offset_y_ff);

   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;

   assign stat.last_iter = (step_ff == lpac_pkg::LAST_STEP);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      if (cmd.prep) begin
         // negating both keeps the ratio and puts the vector in the right half
         if (x_raw < 0) begin
            x_in = -x_raw;
            y_in = -y_raw;
         end else begin
            x_in = x_raw;
            y_in = y_raw;
         end
         z_in    = '0;
         step_in = '0;
      end else if (cmd.iter) begin
         if (y_ff >= 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + lpac_pkg::atan_entry(step_ff);
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - lpac_pkg::atan_entry(step_ff);
         end
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      if (cmd.prep) begin
         xzero_ff <= (x_raw == '0);
         ypos_ff  <= (y_raw > 0);
         yneg_ff  <= (y_raw < 0);
      end
   end

   // shift of the last nonzero point
   logic signed [lpac_pkg::SHIFT_W-1:0] kept_shift_ff;
   logic signed [Z_W-1:0]               z_round;
   logic signed [Z_W-1:0]               z_scaled;

   assign z_round  = z_ff + lpac_pkg::ROUND_HALF;
   assign z_scaled = z_round >>> 8;

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_shift_ff <= '0;
      end else if (cmd.round) begin
         if (xzero_ff) begin
            if (ypos_ff) kept_shift_ff <= lpac_pkg::QUARTER_TURN;
            else if (yneg_ff) kept_shift_ff <= -lpac_pkg::QUARTER_TURN;
            else kept_shift_ff <= '0;
         end else begin
            kept_shift_ff <= z_scaled[lpac_pkg::SHIFT_W-1:0];
         end
      end
   end

   // angle correction, one wrap and clamp
   logic signed [ANG_W-1:0] raw_ext, shift_ext, ang0, ang1, ang2, ang3;

   assign raw_ext   = $signed({3'b000, raw_ff});
   assign shift_ext = ANG_W'(kept_shift_ff);

   always_comb begin
      if (right_hand_ff) ang0 = lpac_pkg::FULL_TURN - raw_ext + shift_ext;
      else               ang0 = raw_ext - shift_ext;
      ang1 = (ang0 > lpac_pkg::FULL_TURN) ? ang0 - lpac_pkg::FULL_TURN : ang0;
      ang2 = (ang1 < 0) ? ang1 + lpac_pkg::FULL_TURN : ang1;
      if (ang2 < 0)                        ang3 = '0;
      else if (ang2 > lpac_pkg::FULL_TURN) ang3 = lpac_pkg::FULL_TURN;
      else                                 ang3 = ang2;
   end

   // output register
   logic                        rsp_valid_ff;
   logic [lpac_pkg::DATA_W-1:0] rsp_data_ff;

   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {stamp_ff, inten_ff, dist_ff, ang3[lpac_pkg::ANGLE_W-1:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/lidar_point_angle_correction_core.sv =====
// ----------------------------------------------------------------------------
// lidar_point_angle_correction_core
// Corrects the scan angle of lidar points for the offset of the optical
// center using an iterative CORDIC arctangent.
//
// req_* takes one point item per handshake; rsp_* returns one corrected item
// for every point with a nonzero distance, in order. Zero-distance items are
// taken and give no result.
// csr_* writes a configuration register by index; it is always ready. It is
// for the user to write it only while the block is idle; nothing enforces it.
// A point with a nonzero distance occupies the block through capture,
// multiply, x/y forming, one CORDIC iteration per cycle on the single
// shared shift-add unit, rounding and the angle correction. The output
// register is loaded at the end of that final step, so rsp_tvalid rises in
// the same cycle in which the next item can be taken.
// A result waiting on rsp_tready does not block the next point until that
// point reaches its final step, which then waits for the output register.
// Synchronous reset restores the register defaults, clears the kept shift
// and empties the output register.
// ----------------------------------------------------------------------------
module lidar_point_angle_correction_core (
   input  logic                         clock,
   input  logic                         reset,
   // point_distance[15:0], raw_angle[31:16], point_intensity[39:32],
   // point_stamp[71:40]
   input  logic [lpac_pkg::DATA_W-1:0]  req_tdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // out_angle[15:0], out_distance[31:16], out_intensity[39:32],
   // out_stamp[71:40]
   output logic [lpac_pkg::DATA_W-1:0]  rsp_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lpac_pkg::INDEX_W-1:0] csr_index,
   input  logic [lpac_pkg::CFG_W-1:0]   csr_data
);

   lpac_pkg::lpac_cmd_type  cmd;
   lpac_pkg::lpac_stat_type stat;

   assign csr_ready = 1'b1;

   lpac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lpac_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== test/tb_lidar_point_angle_correction_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_point_angle_correction_core
// Self-checking bench for the lidar angle correction core. Point items go
// in through the req stream and are predicted with an independent CORDIC
// arctangent model. Corrected items on the rsp stream are checked in order,
// field by field. The run covers directed corner points under the register
// extremes, random configurations with bursty random traffic, and a long
// receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_lidar_point_angle_correction_core;

   localparam int CORDIC_STEPS = lpac_pkg::CORDIC_STEPS;
   localparam int ATAN_ENTRIES = lpac_pkg::ATAN_ENTRIES;
   localparam int DIST_W       = lpac_pkg::DIST_W;
   localparam int ANGLE_W      = lpac_pkg::ANGLE_W;
   localparam int INTEN_W      = lpac_pkg::INTEN_W;
   localparam int STAMP_W      = lpac_pkg::STAMP_W;
   localparam int CFG_W        = lpac_pkg::CFG_W;
   localparam int SHIFT_W      = lpac_pkg::SHIFT_W;
   localparam int DATA_W       = lpac_pkg::DATA_W;
   localparam int INDEX_W      = lpac_pkg::INDEX_W;

   localparam int LATENCY      = CORDIC_STEPS + 5;
   localparam int SETTLE       = 2 * LATENCY;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1400;

   localparam logic [INDEX_W-1:0] REG_UNUSED = 4'd15;

   // atan(2^-i) in hundredths of a degree, scaled by 256
   localparam longint ATAN_Q8 [ATAN_ENTRIES] = '{
      1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
      5730, 2865, 1432, 716, 358, 179, 90, 45,
      22, 11, 6, 3, 1, 1, 0, 0
   };

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [INTEN_W-1:0] intensity;
      logic [ANGLE_W-1:0] raw;
      logic [DIST_W-1:0]  distance;
   } point_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [INTEN_W-1:0] intensity;
      logic [DIST_W-1:0]  distance;
      logic [ANGLE_W-1:0] angle;
   } corrected_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic [DATA_W-1:0]   req_tdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   rsp_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]    csr_data = '0;

   // predictor copy of the registers and the kept shift
   logic                      cfg_right_hand;
   logic signed [CFG_W-1:0]   cfg_offset_x;
   logic signed [CFG_W-1:0]   cfg_offset_y;
   logic [CFG_W-1:0]          cfg_slope;
   logic signed [SHIFT_W-1:0] kept_shift;

   corrected_type corrected_q[$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            stall_pct = 0;
   int            stall_left = 0;
   int            hold_requests = 0;
   int            hold_served = 0;

   lidar_point_angle_correction_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int cordic_shift(input longint x_in, input longint y_in);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = x_in;
      y = y_in;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
      end
      if (x == 0) begin
         return (y > 0) ? 9000 : ((y < 0) ? -9000 : 0);
      end
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_Q8[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_Q8[i];
         end
      end
      return int'((z + 128) >>> 8);
   endfunction

   function automatic bit correct_point(input point_type p, output corrected_type r);
      longint x;
      longint y;
      longint off_x;
      longint off_y;
      longint mm;
      longint slope;
      int     sh;
      int     raw;
      int     ang;
      r = '0;
      if (p.distance == 0) begin
         return 1'b0;
      end
      mm    = p.distance;
      slope = cfg_slope;
      off_x = cfg_offset_x;
      off_y = cfg_offset_y;
      x = mm * 256 + off_x;
      y = ((mm * slope) >>> 8) + off_y;
      sh = cordic_shift(x, y);
      kept_shift = sh[SHIFT_W-1:0];
      raw = p.raw;
      ang = cfg_right_hand ? (36000 - raw + sh) : (raw - sh);
      // single wrap, then clamp for raw angles past a full turn
      if (ang > 36000) begin
         ang = ang - 36000;
      end
      if (ang < 0) begin
         ang = ang + 36000;
      end
      if (ang < 0) begin
         ang = 0;
      end
      if (ang > 36000) begin
         ang = 36000;
      end
      r.angle     = ang[ANGLE_W-1:0];
      r.distance  = p.distance;
      r.intensity = p.intensity;
      r.stamp     = p.stamp;
      return 1'b1;
   endfunction

   function automatic void apply_reg(input logic [INDEX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
      case (idx)
         lpac_pkg::REG_RIGHT_HAND: cfg_right_hand = val[0];
         lpac_pkg::REG_OFFSET_X:   cfg_offset_x   = val;
         lpac_pkg::REG_OFFSET_Y:   cfg_offset_y   = val;
         lpac_pkg::REG_SLOPE:      cfg_slope      = val;
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------- result check

   always @(posedge clock) begin
      corrected_type got;
      corrected_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (corrected_q.size() == 0) begin
            $error("rsp item with no expectation: %h", rsp_tdata);
            error_count++;
         end else begin
            want = corrected_q.pop_front();
            if (got.angle !== want.angle) begin
               $error("out_angle: expected %0d, got %0d", want.angle, got.angle);
               error_count++;
            end
            if (got.distance !== want.distance) begin
               $error("out_distance: expected %0d, got %0d",
                      want.distance, got.distance);
               error_count++;
            end
            if (got.intensity !== want.intensity) begin
               $error("out_intensity: expected %0d, got %0d",
                      want.intensity, got.intensity);
               error_count++;
            end
            if (got.stamp !== want.stamp) begin
               $error("out_stamp: expected %0d, got %0d", want.stamp, got.stamp);
               error_count++;
            end
         end
      end
   end

   // receiver: random stall runs, plus a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left  = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------ drivers

   // returns 1 when the item is expected to give a result
   task automatic send_point(input point_type p, output bit produced);
      corrected_type r;
      req_tdata  <= p;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      produced = correct_point(p, r);
      if (produced) begin
         corrected_q.insert(corrected_q.size(), r);
      end
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (corrected_q.size() > 0) begin
         @(posedge clock);
      end
      // zero-distance items leave nothing to wait for, so let the core settle
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      apply_reg(idx, val);
   endtask

   task automatic configure(input logic mirror, input logic [CFG_W-1:0] off_x,
                            input logic [CFG_W-1:0] off_y, input logic [CFG_W-1:0] slope);
      write_reg(lpac_pkg::REG_RIGHT_HAND, {15'd0, mirror});
      write_reg(lpac_pkg::REG_OFFSET_X, off_x);
      write_reg(lpac_pkg::REG_OFFSET_Y, off_y);
      write_reg(lpac_pkg::REG_SLOPE, slope);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic point_type make_point(input int mm, input int raw,
                                            input int inten, input logic [31:0] stamp);
      point_type p;
      p.distance  = mm[DIST_W-1:0];
      p.raw       = raw[ANGLE_W-1:0];
      p.intensity = inten[INTEN_W-1:0];
      p.stamp     = stamp;
      return p;
   endfunction

   function automatic point_type random_point();
      point_type p;
      case ($urandom_range(9))
         0:       p.distance = '0;
         1:       p.distance = DIST_W'($urandom_range(1, 255));
         2:       p.distance = DIST_W'($urandom_range(65000, 65535));
         default: p.distance = DIST_W'($urandom_range(1, 65535));
      endcase
      // a few raw angles past a full turn
      if ($urandom_range(99) < 4) begin
         p.raw = ANGLE_W'($urandom_range(36000, 65535));
      end else begin
         p.raw = ANGLE_W'($urandom_range(35999));
      end
      p.intensity = INTEN_W'($urandom);
      p.stamp     = $urandom;
      return p;
   endfunction

   function automatic logic [CFG_W-1:0] random_offset(input logic [CFG_W-1:0] nominal);
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return nominal + CFG_W'($urandom_range(512)) - 16'd256;
         default: return CFG_W'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      bit produced;
      send_point(make_point(1, 0, 0, 32'h0000_0000), produced);
      send_point(make_point(65535, 35999, 255, 32'hFFFF_FFFF), produced);
      send_point(make_point(0, 1234, 7, 32'd5), produced);
      pause_sender(3);
      send_point(make_point(1000, 65535, 128, 32'h8000_0000), produced);
      send_point(make_point(1000, 36000, 1, 32'd1), produced);
      wait_for_idle();
   endtask

   task automatic test_register_extremes();
      bit produced;
      // right-hand mirror with default geometry; unused index must be ignored
      configure(1'b1, 16'sd1510, -16'sd4858, 16'd7814);
      write_reg(REG_UNUSED, 16'hFFFF);
      csr_valid <= 1'b0;
      send_point(make_point(1, 0, 3, 32'd100), produced);
      send_point(make_point(65535, 35999, 200, 32'hDEAD_BEEF), produced);
      send_point(make_point(500, 65535, 9, 32'd7), produced);
      send_point(make_point(0, 0, 0, 32'd0), produced);
      wait_for_idle();

      // negative x on the smallest distance
      configure(1'b0, 16'h8000, 16'h7FFF, 16'hFFFF);
      send_point(make_point(1, 100, 11, 32'd12), produced);
      send_point(make_point(65535, 18000, 12, 32'd13), produced);
      wait_for_idle();

      configure(1'b1, 16'h7FFF, 16'h8000, 16'h0000);
      send_point(make_point(1, 0, 14, 32'd14), produced);
      send_point(make_point(65535, 35999, 15, 32'd15), produced);
      wait_for_idle();

      // x exactly zero: y positive, negative, then zero
      configure(1'b0, 16'h8000, 16'd1000, 16'h0000);
      send_point(make_point(128, 0, 16, 32'd16), produced);
      send_point(make_point(128, 35999, 17, 32'd17), produced);
      wait_for_idle();
      configure(1'b0, 16'h8000, -16'sd1000, 16'h0000);
      send_point(make_point(128, 0, 18, 32'd18), produced);
      wait_for_idle();
      configure(1'b1, 16'h8000, 16'h0000, 16'h0000);
      send_point(make_point(128, 500, 19, 32'd19), produced);
      wait_for_idle();
   endtask

   task automatic test_random_traffic(input int target);
      int  results;
      int  phase_target;
      int  phase_results;
      int  burst;
      int  max_gap;
      bit  produced;
      results = 0;
      while (results < target) begin
         wait_for_idle();
         configure(1'($urandom_range(1)),
                   random_offset(16'sd1510), random_offset(-16'sd4858),
                   ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF)
                                            : CFG_W'($urandom));
         case ($urandom_range(3))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            2:       stall_pct = 30;
            default: stall_pct = 60;
         endcase
         max_gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
         phase_target  = $urandom_range(120, 220);
         phase_results = 0;
         while (phase_results < phase_target && results < target) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
               send_point(random_point(), produced);
               if (produced) begin
                  phase_results++;
                  results++;
               end
            end
            pause_sender($urandom_range(max_gap));
         end
      end
      wait_for_idle();
   endtask

   task automatic test_backpressure();
      bit produced;
      configure(1'b0, 16'sd1510, -16'sd4858, 16'd7814);
      stall_pct = 0;
      hold_requests++;
      // the sender keeps offering while the receiver is held off
      repeat (40) begin
         send_point(random_point(), produced);
      end
      wait_for_idle();
      stall_pct = 20;
      repeat (40) begin
         send_point(random_point(), produced);
         pause_sender($urandom_range(3));
      end
      wait_for_idle();
   endtask

   initial begin
      cfg_right_hand = 1'b0;
      cfg_offset_x   = 16'sd1510;
      cfg_offset_y   = -16'sd4858;
      cfg_slope      = 16'd7814;
      kept_shift     = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_random_traffic(RANDOM_ITEMS);
      test_backpressure();

      if (corrected_q.size() != 0) begin
         $error("%0d expected items never arrived", corrected_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
